// ===== sv/msie_pkg.sv =====
`timescale 1ns / 1ps

package msie_pkg;

	localparam int RegCount = 32;
	localparam int RegAddrW = $clog2(RegCount);

	localparam logic [5:0] OP_SPECIAL     = 6'd0;
	localparam logic [5:0] OP_SPECIAL_ALT = 6'd28;
	localparam logic [5:0] OP_BEQ         = 6'd4;
	localparam logic [5:0] OP_BNE         = 6'd5;
	localparam logic [5:0] OP_ADDI        = 6'd8;
	localparam logic [5:0] OP_SLTI        = 6'd10;
	localparam logic [5:0] OP_ANDI        = 6'd12;
	localparam logic [5:0] OP_ORI         = 6'd13;
	localparam logic [5:0] OP_LUI         = 6'd15;

	localparam logic [10:0] FN_SYSCALL = 11'd12;
	localparam logic [10:0] FN_ADD     = 11'd32;
	localparam logic [10:0] FN_SUB     = 11'd34;
	localparam logic [10:0] FN_AND     = 11'd36;
	localparam logic [10:0] FN_OR      = 11'd37;
	localparam logic [10:0] FN_SLT     = 11'd42;
	localparam logic [10:0] FN_MUL     = 11'd2;

	localparam logic [31:0] CALL_PRINT_INT  = 32'd1;
	localparam logic [31:0] CALL_PRINT_CHAR = 32'd11;
	localparam logic [31:0] CALL_EXIT       = 32'd10;

	localparam logic [RegAddrW-1:0] REG_V0 = RegAddrW'(2);
	localparam logic [RegAddrW-1:0] REG_A0 = RegAddrW'(4);

	typedef enum logic [2:0] {
		ACT_CONTINUE   = 3'd0,
		ACT_BRANCH     = 3'd1,
		ACT_PRINT_INT  = 3'd2,
		ACT_PRINT_CHAR = 3'd3,
		ACT_EXIT       = 3'd4,
		ACT_BAD_CALL   = 3'd5
	} action_t;

	typedef struct packed {
		logic                en;
		logic [RegAddrW-1:0] addr;
		logic [31:0]         data;
	} reg_wr_t;

	typedef struct packed {
		action_t             action;
		logic signed [15:0]  branch_offset;
		logic signed [31:0]  print_value;
		logic signed [31:0]  bad_call_code;
	} result_t;

endpackage

// ===== sv/msie_regfile.sv =====
`timescale 1ns / 1ps

module msie_regfile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [msie_pkg::RegAddrW-1:0]    rs_addr,
	input  logic [msie_pkg::RegAddrW-1:0]    rt_addr,
	input  msie_pkg::reg_wr_t                wr,
	output logic [31:0]                      rs_data,
	output logic [31:0]                      rt_data,
	output logic [31:0]                      v0_data,
	output logic [31:0]                      a0_data
);
	import msie_pkg::*;

	logic [31:0]         mem [RegCount];
	logic [RegCount-1:0] valid_q;
	logic [31:0]         v0_q;
	logic [31:0]         a0_q;

	logic [31:0] rs_mem_s1;
	logic [31:0] rt_mem_s1;
	logic [31:0] byp_data_s1;
	logic        rs_vld_s1;
	logic        rt_vld_s1;
	logic        rs_byp_s1;
	logic        rt_byp_s1;

	// Entries read as zero until written; register zero is never written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v0_q    <= '0;
			a0_q    <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
			if (wr.addr == REG_V0) begin
				v0_q <= wr.data;
			end
			if (wr.addr == REG_A0) begin
				a0_q <= wr.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rs_mem_s1 <= mem[rs_addr];
			rt_mem_s1 <= mem[rt_addr];
		end
	end

	// A write on the same edge as a read is forwarded to the read port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_vld_s1 <= 1'b0;
			rt_vld_s1 <= 1'b0;
			rs_byp_s1 <= 1'b0;
			rt_byp_s1 <= 1'b0;
		end else if (rd_en) begin
			rs_vld_s1 <= valid_q[rs_addr];
			rt_vld_s1 <= valid_q[rt_addr];
			rs_byp_s1 <= wr.en && (wr.addr == rs_addr);
			rt_byp_s1 <= wr.en && (wr.addr == rt_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_data_s1 <= wr.data;
		end
	end

	assign rs_data = rs_byp_s1 ? byp_data_s1 : (rs_vld_s1 ? rs_mem_s1 : '0);
	assign rt_data = rt_byp_s1 ? byp_data_s1 : (rt_vld_s1 ? rt_mem_s1 : '0);
	assign v0_data = v0_q;
	assign a0_data = a0_q;

endmodule

// ===== sv/msie_exec.sv =====
`timescale 1ns / 1ps

module msie_exec (
	input  logic [31:0]         instr,
	input  logic [31:0]         vs,
	input  logic [31:0]         vt,
	input  logic [31:0]         v0,
	input  logic [31:0]         a0,
	output msie_pkg::result_t   res,
	output msie_pkg::reg_wr_t   wr
);
	import msie_pkg::*;

	logic [5:0]          op;
	logic [10:0]         fn;
	logic [RegAddrW-1:0] rt;
	logic [RegAddrW-1:0] rd;
	logic [15:0]         imm16;
	logic [31:0]         imm;
	logic [31:0]         result;
	logic [RegAddrW-1:0] dest;
	logic                writes;

	assign op    = instr[31:26];
	assign fn    = instr[10:0];
	assign rt    = instr[20:16];
	assign rd    = instr[15:11];
	assign imm16 = instr[15:0];
	assign imm   = {{16{imm16[15]}}, imm16};

	always_comb begin
		res.action        = ACT_CONTINUE;
		res.branch_offset = '0;
		res.print_value   = '0;
		res.bad_call_code = '0;
		result            = '0;
		dest              = rt;
		writes            = 1'b0;
		unique case (op)
			OP_SPECIAL, OP_SPECIAL_ALT: begin
				dest = rd;
				unique case (fn)
					FN_SYSCALL: begin
						priority if (v0 == CALL_PRINT_INT) begin
							res.action      = ACT_PRINT_INT;
							res.print_value = a0;
						end else if (v0 == CALL_PRINT_CHAR) begin
							res.action      = ACT_PRINT_CHAR;
							res.print_value = a0;
						end else if (v0 == CALL_EXIT) begin
							res.action = ACT_EXIT;
						end else begin
							res.action        = ACT_BAD_CALL;
							res.bad_call_code = v0;
						end
					end
					FN_ADD: begin
						result = vs + vt;
						writes = 1'b1;
					end
					FN_SUB: begin
						result = vs - vt;
						writes = 1'b1;
					end
					FN_AND: begin
						result = vs & vt;
						writes = 1'b1;
					end
					FN_OR: begin
						result = vs | vt;
						writes = 1'b1;
					end
					FN_SLT: begin
						result = {31'd0, $signed(vs) < $signed(vt)};
						writes = 1'b1;
					end
					FN_MUL: begin
						result = vs * vt;
						writes = 1'b1;
					end
					default: begin
					end
				endcase
			end
			OP_BEQ: begin
				if (vs == vt) begin
					res.action        = ACT_BRANCH;
					res.branch_offset = imm16;
				end
			end
			OP_BNE: begin
				if (vs != vt) begin
					res.action        = ACT_BRANCH;
					res.branch_offset = imm16;
				end
			end
			OP_ADDI: begin
				result = vs + imm;
				writes = 1'b1;
			end
			OP_SLTI: begin
				result = {31'd0, $signed(vs) < $signed(imm)};
				writes = 1'b1;
			end
			OP_ANDI: begin
				result = vs & imm;
				writes = 1'b1;
			end
			OP_ORI: begin
				result = vs | imm;
				writes = 1'b1;
			end
			OP_LUI: begin
				result = {imm16, 16'd0};
				writes = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign wr.en   = writes && (dest != '0);
	assign wr.addr = dest;
	assign wr.data = result;

endmodule

// ===== sv/mips_subset_instruction_executor_top.sv =====
`timescale 1ns / 1ps
// An instruction is held in an input register, then its result in the output register.
// Throughput: one instruction per cycle unless stalled; the register file read port is
// registered; the execute stage writes back as its result moves to the output register.
// Reset is asynchronous and clears the pipeline; every register then reads as zero.
// There is no clearing pass, so instructions are taken from the first cycle after reset.

module mips_subset_instruction_executor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         instruction,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          action,
	output logic signed [15:0]  branch_offset,
	output logic signed [31:0]  print_value,
	output logic signed [31:0]  bad_call_code
);
	import msie_pkg::*;

	logic        vld_s1;
	logic [31:0] instr_s1;
	logic        vld_s2;
	result_t     res_s2;

	logic        in_xfer;
	logic        move_s1;
	logic [31:0] vs;
	logic [31:0] vt;
	logic [31:0] v0;
	logic [31:0] a0;
	result_t     exec_res;
	reg_wr_t     exec_wr;
	reg_wr_t     wr;

	assign move_s1  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || move_s1;
	assign in_xfer  = in_valid && in_ready;

	// The register write takes effect only once, when the instruction leaves the stage.
	assign wr.en   = move_s1 && exec_wr.en;
	assign wr.addr = exec_wr.addr;
	assign wr.data = exec_wr.data;

	msie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.rs_addr (instruction[25:21]),
		.rt_addr (instruction[20:16]),
		.wr      (wr),
		.rs_data (vs),
		.rt_data (vt),
		.v0_data (v0),
		.a0_data (a0)
	);

	msie_exec u_exec (
		.instr (instr_s1),
		.vs    (vs),
		.vt    (vt),
		.v0    (v0),
		.a0    (a0),
		.res   (exec_res),
		.wr    (exec_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (!vld_s2 || out_ready) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			instr_s1 <= instruction;
		end
		if (move_s1) begin
			res_s2 <= exec_res;
		end
	end

	assign out_valid     = vld_s2;
	assign action        = res_s2.action;
	assign branch_offset = res_s2.branch_offset;
	assign print_value   = res_s2.print_value;
	assign bad_call_code = res_s2.bad_call_code;

endmodule

// ===== sim/msie_result_checker.sv =====
`timescale 1ns / 1ps

module msie_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [31:0]        instruction,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         action,
	input  logic signed [15:0] branch_offset,
	input  logic signed [31:0] print_value,
	input  logic signed [31:0] bad_call_code,
	output int                 mismatches,
	output int                 outstanding,
	output int                 results_compared
);
	import msie_pkg::*;

	logic [31:0] gpr [RegCount];
	result_t     due_outcomes [$];
	result_t     predicted;
	result_t     oldest;

	task automatic write_gpr(input logic [RegAddrW-1:0] idx, input logic [31:0] value);
		if (idx != '0) begin
			gpr[idx] = value;
		end
	endtask

	task automatic execute_word(input logic [31:0] word, output result_t res);
		logic [5:0]          op;
		logic [10:0]         fn;
		logic [RegAddrW-1:0] rs;
		logic [RegAddrW-1:0] rt;
		logic [RegAddrW-1:0] rd;
		logic [15:0]         imm16;
		logic [31:0]         imm;
		logic [31:0]         vs;
		logic [31:0]         vt;
		logic [31:0]         v0;
		op    = word[31:26];
		rs    = word[25:21];
		rt    = word[20:16];
		rd    = word[15:11];
		fn    = word[10:0];
		imm16 = word[15:0];
		imm   = {{16{imm16[15]}}, imm16};
		vs    = gpr[rs];
		vt    = gpr[rt];
		res   = '0;
		res.action = ACT_CONTINUE;
		if (op == OP_SPECIAL || op == OP_SPECIAL_ALT) begin
			case (fn)
				FN_SYSCALL: begin
					v0 = gpr[REG_V0];
					if (v0 == CALL_PRINT_INT) begin
						res.action      = ACT_PRINT_INT;
						res.print_value = gpr[REG_A0];
					end else if (v0 == CALL_PRINT_CHAR) begin
						res.action      = ACT_PRINT_CHAR;
						res.print_value = gpr[REG_A0];
					end else if (v0 == CALL_EXIT) begin
						res.action = ACT_EXIT;
					end else begin
						res.action        = ACT_BAD_CALL;
						res.bad_call_code = v0;
					end
				end
				FN_ADD: write_gpr(rd, vs + vt);
				FN_SUB: write_gpr(rd, vs - vt);
				FN_AND: write_gpr(rd, vs & vt);
				FN_OR:  write_gpr(rd, vs | vt);
				FN_SLT: write_gpr(rd, {31'b0, $signed(vs) < $signed(vt)});
				FN_MUL: write_gpr(rd, vs * vt);
				default: ;
			endcase
		end else begin
			case (op)
				OP_BEQ: begin
					if (vs == vt) begin
						res.action        = ACT_BRANCH;
						res.branch_offset = imm16;
					end
				end
				OP_BNE: begin
					if (vs != vt) begin
						res.action        = ACT_BRANCH;
						res.branch_offset = imm16;
					end
				end
				OP_ADDI: write_gpr(rt, vs + imm);
				OP_SLTI: write_gpr(rt, {31'b0, $signed(vs) < $signed(imm)});
				OP_ANDI: write_gpr(rt, vs & imm);
				OP_ORI:  write_gpr(rt, vs | imm);
				OP_LUI:  write_gpr(rt, {imm16, 16'h0000});
				default: ;
			endcase
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			mismatches++;
		end
	endtask

	// The output side is handled before the input side, as no result can stem
	// from an instruction whose transfer happens at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) begin
				gpr[i] = '0;
			end
			due_outcomes.delete();
			mismatches       = 0;
			results_compared = 0;
			outstanding      = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_outcomes.size() == 0) begin
					$error("result transfer with no instruction outstanding");
					mismatches++;
				end else begin
					oldest = due_outcomes.pop_front();
					compare_field("action", 32'(oldest.action), 32'(action));
					compare_field("branch_offset", 32'(oldest.branch_offset),
						32'(branch_offset));
					compare_field("print_value", oldest.print_value, print_value);
					compare_field("bad_call_code", oldest.bad_call_code, bad_call_code);
					results_compared++;
				end
			end
			if (in_valid && in_ready) begin
				execute_word(instruction, predicted);
				due_outcomes.push_back(predicted);
			end
			outstanding = due_outcomes.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import msie_pkg::*;

	localparam int RandomCount = 500;
	localparam int CycleLimit  = 200000;

	typedef enum int {
		KIND_NOISE,
		KIND_BROKEN,
		KIND_ALU,
		KIND_IMMEDIATE,
		KIND_SELF_BRANCH,
		KIND_SYSCALL
	} stim_kind_t;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_SPARSE
	} rx_mode_t;

	logic               clk;
	logic               arst_n      = 1'b1;
	logic               in_valid    = 1'b0;
	logic [31:0]        instruction = '0;
	logic               out_ready   = 1'b0;
	logic               in_ready;
	logic               out_valid;
	logic [2:0]         action;
	logic signed [15:0] branch_offset;
	logic signed [31:0] print_value;
	logic signed [31:0] bad_call_code;

	int         mismatches;
	int         outstanding;
	int         results_compared;
	int         sent_count     = 0;
	int         directed_count = 0;
	int         burst_left     = 0;
	int         gap_len        = 0;
	int         cycle_count    = 0;
	int         rx_count       = 0;
	rx_mode_t   rx_mode        = RX_ALWAYS;
	stim_kind_t kind;
	int         roll;

	mips_subset_instruction_executor_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.instruction  (instruction),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.branch_offset(branch_offset),
		.print_value  (print_value),
		.bad_call_code(bad_call_code)
	);

	msie_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.instruction     (instruction),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.action          (action),
		.branch_offset   (branch_offset),
		.print_value     (print_value),
		.bad_call_code   (bad_call_code),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_compared(results_compared)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		rx_count++;
		if (rx_count % 60 == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
		end
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
			default:   out_ready <= (rx_count % 4 == 0);
		endcase
	end

	function automatic logic [31:0] rtype(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] rd, input logic [10:0] fn);
		return {op, rs, rt, rd, fn};
	endfunction

	function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 4) != 0) begin
			return 5'($urandom_range(0, 7));
		end
		return 5'($urandom);
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'h7FFF;
			2:       return 16'h8000;
			3:       return 16'hFFFF;
			4:       return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [10:0] pick_alu_fn();
		case ($urandom_range(0, 5))
			0:       return FN_ADD;
			1:       return FN_SUB;
			2:       return FN_AND;
			3:       return FN_OR;
			4:       return FN_SLT;
			default: return FN_MUL;
		endcase
	endfunction

	function automatic logic [5:0] pick_imm_op();
		case ($urandom_range(0, 6))
			0:       return OP_BEQ;
			1:       return OP_BNE;
			2:       return OP_ADDI;
			3:       return OP_SLTI;
			4:       return OP_ANDI;
			5:       return OP_ORI;
			default: return OP_LUI;
		endcase
	endfunction

	function automatic logic [5:0] pick_special();
		return $urandom_range(0, 1) ? OP_SPECIAL_ALT : OP_SPECIAL;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_word(input logic [31:0] word);
		if (burst_left == 0) begin
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (sent_count >= 250 && sent_count < 350) begin
				gap_len = 0;
			end
			if (gap_len > 0) begin
				in_valid <= 1'b0;
				repeat (gap_len) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid    <= 1'b1;
		instruction <= word;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent_count++;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(itype(OP_LUI, 0, 1, 16'h8000));
		send_word(itype(OP_ADDI, 0, 2, 16'hFFFF));
		send_word(rtype(OP_SPECIAL, 1, 2, 3, FN_ADD));
		send_word(rtype(OP_SPECIAL_ALT, 3, 3, 5, FN_ADD));
		send_word(rtype(OP_SPECIAL, 0, 1, 6, FN_SUB));
		send_word(rtype(OP_SPECIAL, 2, 3, 7, FN_AND));
		send_word(rtype(OP_SPECIAL, 1, 3, 8, FN_OR));
		send_word(rtype(OP_SPECIAL, 1, 3, 9, FN_SLT));
		send_word(itype(OP_SLTI, 3, 10, 16'hFFFF));
		send_word(rtype(OP_SPECIAL_ALT, 3, 3, 11, FN_MUL));
		send_word(rtype(OP_SPECIAL, 1, 2, 12, FN_MUL));
		send_word(itype(OP_ANDI, 2, 13, 16'h8000));
		send_word(itype(OP_ORI, 0, 14, 16'h8000));
		send_word(rtype(OP_SPECIAL, 2, 2, 0, FN_ADD));
		send_word(itype(OP_BEQ, 0, 0, 16'h0000));
		send_word(itype(OP_BNE, 1, 2, 16'h8000));
		send_word(itype(OP_BEQ, 1, 3, 16'h7FFF));
		send_word(itype(OP_BNE, 0, 0, 16'h7FFF));
		send_word(rtype(OP_SPECIAL, 0, 0, 0, FN_SYSCALL));
		send_word(itype(OP_ADDI, 0, REG_V0, 16'(CALL_PRINT_INT)));
		send_word(rtype(OP_SPECIAL, 1, 0, REG_A0, FN_OR));
		send_word(rtype(OP_SPECIAL, 0, 0, 0, FN_SYSCALL));
		send_word(itype(OP_ORI, 0, REG_V0, 16'(CALL_PRINT_CHAR)));
		send_word(rtype(OP_SPECIAL_ALT, 31, 31, 31, FN_SYSCALL));
		send_word(itype(OP_ADDI, 0, REG_V0, 16'(CALL_EXIT)));
		send_word(rtype(OP_SPECIAL, 0, 0, 0, FN_SYSCALL));
		send_word(32'hFFFF_FFFF);
		send_word(rtype(OP_SPECIAL, 1, 2, 3, 11'h7FF));
		directed_count = sent_count;

		// Mostly well-formed instructions on a few registers so that values build
		// up and feed later branches and system calls; the rest is noise.
		while (sent_count < directed_count + RandomCount) begin
			roll = $urandom_range(0, 99);
			kind = roll < 8  ? KIND_NOISE :
			       roll < 15 ? KIND_BROKEN :
			       roll < 50 ? KIND_ALU :
			       roll < 80 ? KIND_IMMEDIATE :
			       roll < 85 ? KIND_SELF_BRANCH : KIND_SYSCALL;
			case (kind)
				KIND_NOISE: send_word($urandom);
				KIND_BROKEN: begin
					if ($urandom_range(0, 1)) begin
						send_word({pick_special(), 15'($urandom), 11'($urandom)});
					end else begin
						send_word({6'($urandom), 26'($urandom)});
					end
				end
				KIND_ALU: send_word(rtype(pick_special(), pick_reg(), pick_reg(),
					pick_reg(), pick_alu_fn()));
				KIND_IMMEDIATE: send_word(itype(pick_imm_op(), pick_reg(), pick_reg(),
					pick_imm()));
				KIND_SELF_BRANCH: begin
					roll = pick_reg();
					send_word(itype($urandom_range(0, 1) ? OP_BEQ : OP_BNE, 5'(roll),
						5'(roll), pick_imm()));
				end
				default: begin
					case ($urandom_range(0, 4))
						0: send_word(itype(OP_ADDI, 0, REG_V0, 16'(CALL_PRINT_INT)));
						1: send_word(itype(OP_ADDI, 0, REG_V0, 16'(CALL_PRINT_CHAR)));
						2: send_word(itype(OP_ADDI, 0, REG_V0, 16'(CALL_EXIT)));
						3: send_word(itype(OP_ADDI, pick_reg(), REG_V0, pick_imm()));
						default: ;
					endcase
					if ($urandom_range(0, 1)) begin
						send_word(itype($urandom_range(0, 1) ? OP_LUI : OP_ADDI, pick_reg(),
							REG_A0, pick_imm()));
					end
					send_word({pick_special(), 15'($urandom), FN_SYSCALL});
				end
			endcase
		end
		in_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Issued %0d instruction words, %0d of them directed, the rest random.",
			sent_count, directed_count);
		$display("Compared %0d results against the prediction, %0d mismatches.",
			results_compared, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/msie_pkg.sv
sv/msie_regfile.sv
sv/msie_exec.sv
sv/mips_subset_instruction_executor_top.sv
sim/msie_result_checker.sv
sim/tb_top.sv
